@@ sv/ntcti_pkg.sv @@
// Package for the NTC table interpolator: field widths, command and status codes,
// register indexes and register reset values. No dependencies.
package ntcti_pkg;

  localparam int ADC_W  = 16;
  localparam int TEMP_W = 16;
  localparam int STEP_W = 10;
  localparam int CNT_W  = 6;
  localparam int CFG_AW = 5;

  typedef logic [1:0] range_t;
  localparam range_t RANGE_IN    = 2'd0;
  localparam range_t RANGE_OVER  = 2'd1;
  localparam range_t RANGE_UNDER = 2'd2;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_CONVERT = 1'b1;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_ENTRIES = 3'd0;
  localparam reg_idx_t REG_STEP    = 3'd1;
  localparam reg_idx_t REG_START   = 3'd2;
  localparam reg_idx_t REG_OVER    = 3'd3;
  localparam reg_idx_t REG_UNDER   = 3'd4;

  localparam logic [CNT_W-1:0]  ENTRIES_RST = 6'd32;
  localparam logic [STEP_W-1:0] STEP_RST    = 10'd50;
  localparam logic [TEMP_W-1:0] START_RST   = 16'hFE70;
  localparam logic [TEMP_W-1:0] OVER_RST    = 16'd1250;
  localparam logic [TEMP_W-1:0] UNDER_RST   = 16'hFE70;

endpackage

@@ sv/ntc_table_interpolator_unit.sv @@
// NTC table interpolator: one word accepted per cycle while busy is low; the binary
// search, multiply and one-bit-per-stage divide are all pipelined, and each search stage
// reads its own copy of the table.
// Reset clears the stage valid bits and loads the register reset values; the
// calibration table is undefined until loaded. busy is high during reset and is cleared once reset is released.
// Uses ntcti_pkg and ntcti_ram.
module ntc_table_interpolator_unit #(
  parameter int TABLE_DEPTH = 32,
  parameter int ENTRY_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_command,
  input  logic [4:0]                     in_entry_index,
  input  logic [15:0]                    in_entry_value,
  input  logic [15:0]                    in_adc_sum,
  output logic                           out_valid,
  output logic signed [15:0]             out_temperature,
  output logic [1:0]                     out_range_status,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [ntcti_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  localparam int EW    = ENTRY_WIDTH;
  localparam int IW    = $clog2(TABLE_DEPTH);
  localparam int SRCH  = $clog2(TABLE_DEPTH - 1);
  localparam int NSTEP = (SRCH < 1) ? 1 : SRCH;
  localparam int AW    = ntcti_pkg::ADC_W;
  localparam int CW    = (EW > AW) ? EW : AW;
  localparam int TW    = ntcti_pkg::TEMP_W;
  localparam int QW    = ntcti_pkg::STEP_W;
  localparam int NW    = QW + CW + 1;
  localparam int LAT   = 5 + NSTEP + QW;

  typedef struct packed {
    logic                wr;
    logic                cv;
    logic [AW-1:0]       adc;
    logic [IW-1:0]       waddr;
    logic [EW-1:0]       wdata;
    logic [IW-1:0]       lo;
    logic [IW-1:0]       hi;
    logic [IW-1:0]       mid;
    logic                act;
    ntcti_pkg::range_t   status;
  } srch_t;

  typedef struct packed {
    logic                cv;
    logic                pt;
    ntcti_pkg::range_t   status;
    logic [TW-1:0]       tval;
    logic [EW-1:0]       vd;
    logic [CW-1:0]       diff;
  } calc_t;

  typedef struct packed {
    logic                cv;
    logic                pt;
    ntcti_pkg::range_t   status;
    logic [TW-1:0]       tval;
    logic [EW-1:0]       dvsr;
    logic [CW:0]         rem;
    logic [QW-1:0]       nlow;
    logic [QW-1:0]       q;
  } div_t;

  // Configuration registers.
  logic [ntcti_pkg::CNT_W-1:0]  entries_r;
  logic [ntcti_pkg::STEP_W-1:0] step_r;
  logic [TW-1:0]                start_r;
  logic [TW-1:0]                over_r;
  logic [TW-1:0]                under_r;
  logic                         busy_r;
  logic                         cfg_wr;

  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= ntcti_pkg::ENTRIES_RST;
      step_r    <= ntcti_pkg::STEP_RST;
      start_r   <= ntcti_pkg::START_RST;
      over_r    <= ntcti_pkg::OVER_RST;
      under_r   <= ntcti_pkg::UNDER_RST;
      busy_r    <= 1'b1;
    end else begin
      busy_r <= 1'b0;
      if (cfg_wr) begin
        unique case (paddr[4:2])
          ntcti_pkg::REG_ENTRIES: entries_r <= pwdata[ntcti_pkg::CNT_W-1:0];
          ntcti_pkg::REG_STEP:    step_r    <= pwdata[ntcti_pkg::STEP_W-1:0];
          ntcti_pkg::REG_START:   start_r   <= pwdata[TW-1:0];
          ntcti_pkg::REG_OVER:    over_r    <= pwdata[TW-1:0];
          ntcti_pkg::REG_UNDER:   under_r   <= pwdata[TW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      ntcti_pkg::REG_ENTRIES: prdata = 32'(entries_r);
      ntcti_pkg::REG_STEP:    prdata = 32'(step_r);
      ntcti_pkg::REG_START:   prdata = {{(32-TW){start_r[TW-1]}}, start_r};
      ntcti_pkg::REG_OVER:    prdata = {{(32-TW){over_r[TW-1]}}, over_r};
      ntcti_pkg::REG_UNDER:   prdata = {{(32-TW){under_r[TW-1]}}, under_r};
      default:                prdata = '0;
    endcase
  end

  assign busy = busy_r;

  // Entry stage: clamp the entry count, read both table ends.
  logic        accept;
  logic [31:0] cnt32;
  logic [31:0] hi32;
  logic [31:0] idx32;
  logic [IW-1:0] hi0;

  srch_t s_r   [1:NSTEP+2];
  srch_t s_nxt [1:NSTEP+2];

  logic [EW-1:0] rz_q, rh_q, rl_q, rr_q;
  logic [EW-1:0] rs_q [0:NSTEP-1];

  assign accept = start & ~busy_r;

  always_comb begin
    cnt32 = 32'(entries_r);
    if (cnt32 > 32'(TABLE_DEPTH)) begin
      cnt32 = 32'(TABLE_DEPTH);
    end else if (cnt32 == 32'd0) begin
      cnt32 = 32'd1;
    end
    hi32  = cnt32 - 32'd1;
    hi0   = hi32[IW-1:0];
    idx32 = 32'(in_entry_index);

    s_nxt[1].wr     = accept & (in_command == ntcti_pkg::CMD_LOAD) &
                      (idx32 < 32'(TABLE_DEPTH));
    s_nxt[1].cv     = accept & (in_command == ntcti_pkg::CMD_CONVERT);
    s_nxt[1].adc    = in_adc_sum;
    s_nxt[1].waddr  = idx32[IW-1:0];
    s_nxt[1].wdata  = EW'(in_entry_value);
    s_nxt[1].lo     = '0;
    s_nxt[1].hi     = hi0;
    s_nxt[1].mid    = '0;
    s_nxt[1].act    = 1'b0;
    s_nxt[1].status = ntcti_pkg::RANGE_IN;
  end

  ntcti_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_zero (
    .clk(clk), .we(s_nxt[1].wr), .waddr(s_nxt[1].waddr), .wdata(s_nxt[1].wdata),
    .raddr('0), .rdata(rz_q)
  );

  ntcti_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_end (
    .clk(clk), .we(s_nxt[1].wr), .waddr(s_nxt[1].waddr), .wdata(s_nxt[1].wdata),
    .raddr(hi0), .rdata(rh_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_r[1].wr <= 1'b0;
      s_r[1].cv <= 1'b0;
    end else begin
      s_r[1] <= s_nxt[1];
    end
  end

  // Search stages. Each rank applies the previous probe, then probes the new midpoint
  // in its own table copy; a load writes each copy as it passes that rank.
  for (genvar k = 1; k <= NSTEP + 1; k++) begin : g_srch
    logic [EW-1:0]      probe;
    ntcti_pkg::range_t  st;
    logic [CW-1:0]      adc_c;
    logic [IW-1:0]      lo_u, hi_u;
    logic [IW:0]        sum, span;

    if (k == 1) begin : g_first
      always_comb begin
        probe = '0;
        if (CW'(s_r[1].adc) <= CW'(rh_q)) begin
          st = ntcti_pkg::RANGE_OVER;
        end else if (CW'(s_r[1].adc) >= CW'(rz_q)) begin
          st = ntcti_pkg::RANGE_UNDER;
        end else begin
          st = ntcti_pkg::RANGE_IN;
        end
      end
    end else begin : g_next
      assign probe = rs_q[k-2];
      assign st    = s_r[k].status;
    end

    always_comb begin
      adc_c = CW'(s_r[k].adc);
      lo_u  = s_r[k].lo;
      hi_u  = s_r[k].hi;
      if (s_r[k].act) begin
        if (adc_c > CW'(probe)) begin
          hi_u = s_r[k].mid;
        end else begin
          lo_u = s_r[k].mid;
        end
      end
      sum  = {1'b0, lo_u} + {1'b0, hi_u};
      span = {1'b0, hi_u} - {1'b0, lo_u};
      s_nxt[k+1]        = s_r[k];
      s_nxt[k+1].lo     = lo_u;
      s_nxt[k+1].hi     = hi_u;
      s_nxt[k+1].mid    = sum[IW:1];
      s_nxt[k+1].act    = span > (IW+1)'(1);
      s_nxt[k+1].status = st;
    end

    if (k <= NSTEP) begin : g_probe
      ntcti_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_probe (
        .clk(clk), .we(s_r[k].wr), .waddr(s_r[k].waddr), .wdata(s_r[k].wdata),
        .raddr(s_nxt[k+1].mid), .rdata(rs_q[k-1])
      );
    end else begin : g_pair
      ntcti_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_left (
        .clk(clk), .we(s_r[k].wr), .waddr(s_r[k].waddr), .wdata(s_r[k].wdata),
        .raddr(lo_u), .rdata(rl_q)
      );
      ntcti_ram #(.WIDTH(EW), .DEPTH(TABLE_DEPTH)) u_ram_right (
        .clk(clk), .we(s_r[k].wr), .waddr(s_r[k].waddr), .wdata(s_r[k].wdata),
        .raddr(hi_u), .rdata(rr_q)
      );
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        s_r[k+1].wr <= 1'b0;
        s_r[k+1].cv <= 1'b0;
      end else begin
        s_r[k+1] <= s_nxt[k+1];
      end
    end
  end

  // Bracketing pair known: grid temperatures, divisor and offset.
  localparam int PW = IW + QW;
  localparam int A  = NSTEP + 2;

  calc_t         c_r, c_nxt;
  logic [PW-1:0] lo_p, hi_p;
  logic [TW-1:0] grid_t, base_t;
  logic          hit;

  always_comb begin
    lo_p   = PW'(s_r[A].lo) * PW'(step_r);
    hi_p   = PW'(s_r[A].hi) * PW'(step_r);
    grid_t = start_r + TW'(lo_p);
    base_t = start_r + TW'(hi_p);
    hit    = CW'(s_r[A].adc) >= CW'(rl_q);

    c_nxt.cv     = s_r[A].cv;
    c_nxt.status = s_r[A].status;
    c_nxt.vd     = rl_q - rr_q;
    c_nxt.diff   = CW'(s_r[A].adc) - CW'(rr_q);
    c_nxt.pt     = (s_r[A].status != ntcti_pkg::RANGE_IN) || hit || (c_nxt.vd == '0);
    if (s_r[A].status == ntcti_pkg::RANGE_OVER) begin
      c_nxt.tval = over_r;
    end else if (s_r[A].status == ntcti_pkg::RANGE_UNDER) begin
      c_nxt.tval = under_r;
    end else if (hit) begin
      c_nxt.tval = grid_t;
    end else begin
      c_nxt.tval = base_t;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_r.cv <= 1'b0;
    end else begin
      c_r <= c_nxt;
    end
  end

  // Numerator with half the divisor added for rounding.
  div_t          d_r   [0:QW];
  div_t          d_nxt [0:QW];
  logic [NW-1:0] num;

  always_comb begin
    num = NW'(step_r) * NW'(c_r.diff) + NW'(c_r.vd >> 1);
    d_nxt[0].cv     = c_r.cv;
    d_nxt[0].pt     = c_r.pt;
    d_nxt[0].status = c_r.status;
    d_nxt[0].tval   = c_r.tval;
    d_nxt[0].dvsr   = c_r.vd;
    d_nxt[0].rem    = num[NW-1:QW];
    d_nxt[0].nlow   = num[QW-1:0];
    d_nxt[0].q      = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_r[0].cv <= 1'b0;
    end else begin
      d_r[0] <= d_nxt[0];
    end
  end

  // Restoring divide, one quotient bit per rank. The quotient never exceeds the step,
  // so the numerator bits above the quotient width start out below the divisor.
  for (genvar i = 0; i < QW; i++) begin : g_div
    logic [CW+1:0] trial, dz, sub;

    always_comb begin
      trial = {d_r[i].rem, d_r[i].nlow[QW-1]};
      dz    = (CW+2)'(d_r[i].dvsr);
      sub   = trial - dz;
      d_nxt[i+1]      = d_r[i];
      d_nxt[i+1].nlow = d_r[i].nlow << 1;
      if (trial >= dz) begin
        d_nxt[i+1].rem = sub[CW:0];
        d_nxt[i+1].q   = {d_r[i].q[QW-2:0], 1'b1};
      end else begin
        d_nxt[i+1].rem = trial[CW:0];
        d_nxt[i+1].q   = {d_r[i].q[QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_r[i+1].cv <= 1'b0;
      end else begin
        d_r[i+1] <= d_nxt[i+1];
      end
    end
  end

  // Result word register.
  logic              out_valid_r, out_valid_nxt;
  logic [TW-1:0]     out_temp_r, out_temp_nxt;
  ntcti_pkg::range_t out_status_r;

  always_comb begin
    out_valid_nxt = d_r[QW].cv;
    if (d_r[QW].pt) begin
      out_temp_nxt = d_r[QW].tval;
    end else begin
      out_temp_nxt = d_r[QW].tval - TW'(d_r[QW].q);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_temp_r   <= out_temp_nxt;
    out_status_r <= d_r[QW].status;
  end

  assign out_valid        = out_valid_r;
  assign out_temperature  = out_temp_r;
  assign out_range_status = out_status_r;

  // Every convert word yields exactly one result word.
  a_convert_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == ntcti_pkg::CMD_CONVERT) |-> ##LAT out_valid)
    else $error("convert word produced no result");

  a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_command == ntcti_pkg::CMD_LOAD) |-> ##LAT !out_valid)
    else $error("load word produced a result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_range_status == ntcti_pkg::RANGE_IN ||
                   out_range_status == ntcti_pkg::RANGE_OVER ||
                   out_range_status == ntcti_pkg::RANGE_UNDER))
    else $error("invalid range status");

endmodule

@@ sv/ntcti_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ntcti_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
